// File: rtl/core/mbpf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbpf_pkg
// Shared types and constants for the masked byte pattern finder.
// ----------------------------------------------------------------------------
package mbpf_pkg;

    localparam int SIG_BYTES    = 16;  // signature bytes held in the registers
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_ADDR_W   = 5;
    localparam int OUT_OFFSET_W = 32;
    localparam int LEN_W        = 5;

    // register index, taken from paddr[4:3]
    localparam logic [1:0] REG_PAT_LO = 2'd0;
    localparam logic [1:0] REG_PAT_HI = 2'd1;
    localparam logic [1:0] REG_CARE   = 2'd2;
    localparam logic [1:0] REG_LENGTH = 2'd3;

    typedef logic [SIG_BYTES-1:0][7:0] t_signature;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic                    found;
        logic [OUT_OFFSET_W-1:0] match_offset;
    } t_out_item;

endpackage : mbpf_pkg
`default_nettype wire

// File: rtl/core/mbpf_matcher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbpf_matcher
// Masked compare of the byte window against the signature, one pass.
// ----------------------------------------------------------------------------
module mbpf_matcher #(
    parameter int WIN_BYTES = 16
) (
    input  wire logic [WIN_BYTES-1:0][7:0]       i_window,   // index 0 is newest
    input  wire mbpf_pkg::t_signature            i_signature,
    input  wire logic [mbpf_pkg::SIG_BYTES-1:0]  i_care,
    input  wire logic [mbpf_pkg::LEN_W-1:0]      i_len,      // 1..WIN_BYTES
    output logic                                 o_hit
);

    localparam int IDX_W = (WIN_BYTES > 1) ? $clog2(WIN_BYTES) : 1;

    logic [IDX_W-1:0] idx [WIN_BYTES];

    // signature byte n lines up with window byte len-1-n
    always_comb begin
        o_hit = 1'b1;
        for (int n = 0; n < WIN_BYTES; n++) begin
            idx[n] = IDX_W'(i_len - mbpf_pkg::LEN_W'(n + 1));
            if ((mbpf_pkg::LEN_W'(n) < i_len) && i_care[n]) begin
                if (i_window[idx[n]] != i_signature[n]) begin
                    o_hit = 1'b0;
                end
            end
        end
    end

endmodule : mbpf_matcher
`default_nettype wire

// File: rtl/core/masked_byte_pattern_finder.sv
`default_nettype none
// Latency: a result is valid the cycle after the last byte of a buffer is taken.
// Throughput: one byte per cycle; the masked compare over the whole window is a
//   single combinational pass between the window registers and the match state.
// A last byte is held off only while the previous result is still stalled.
// Reset: synchronous, active low; clears search state, output valid and the
//   registers to their defaults (care mask all ones, length one).
// ----------------------------------------------------------------------------
// masked_byte_pattern_finder
// Streams a buffer byte by byte, looks for a masked signature of up to 16
// bytes and reports the highest start offset of any full match at buffer end.
// ----------------------------------------------------------------------------
module masked_byte_pattern_finder #(
    parameter int MAX_PATTERN_BYTES = 16,
    parameter int OFFSET_BITS       = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // byte request channel
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire mbpf_pkg::t_in_item                i_in_data,
    // result channel
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output mbpf_pkg::t_out_item                    o_out_data,
    // configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [mbpf_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [mbpf_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [mbpf_pkg::CFG_DATA_W-1:0]        prdata,
    output logic                                   pready
);

    // Only the first min(MAX_PATTERN_BYTES, 16) window bytes can ever be compared,
    // so the window is no deeper than that.
    localparam int WIN_BYTES = (MAX_PATTERN_BYTES < mbpf_pkg::SIG_BYTES) ?
                               MAX_PATTERN_BYTES : mbpf_pkg::SIG_BYTES;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [63:0]                       r_pat_lo;
    logic [63:0]                       r_pat_hi;
    logic [mbpf_pkg::SIG_BYTES-1:0]    r_care;
    logic [mbpf_pkg::LEN_W-1:0]        r_len;
    logic                              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo <= '0;
            r_pat_hi <= '0;
            r_care   <= '1;
            r_len    <= mbpf_pkg::LEN_W'(1);
        end else if (cfg_wr) begin
            unique case (paddr[4:3])
                mbpf_pkg::REG_PAT_LO: r_pat_lo <= pwdata;
                mbpf_pkg::REG_PAT_HI: r_pat_hi <= pwdata;
                mbpf_pkg::REG_CARE:   r_care   <= pwdata[mbpf_pkg::SIG_BYTES-1:0];
                mbpf_pkg::REG_LENGTH: r_len    <= pwdata[mbpf_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:3])
            mbpf_pkg::REG_PAT_LO: prdata = r_pat_lo;
            mbpf_pkg::REG_PAT_HI: prdata = r_pat_hi;
            mbpf_pkg::REG_CARE:   prdata = mbpf_pkg::CFG_DATA_W'(r_care);
            mbpf_pkg::REG_LENGTH: prdata = mbpf_pkg::CFG_DATA_W'(r_len);
            default:              prdata = '0;
        endcase
    end

    // Effective length: zero reads as one, anything past the window is capped.
    logic [mbpf_pkg::LEN_W-1:0] eff_len;

    always_comb begin
        if (r_len == '0) begin
            eff_len = mbpf_pkg::LEN_W'(1);
        end else if (r_len > mbpf_pkg::LEN_W'(WIN_BYTES)) begin
            eff_len = mbpf_pkg::LEN_W'(WIN_BYTES);
        end else begin
            eff_len = r_len;
        end
    end

    // ------------------------------------------------------------------
    // Search state
    // ------------------------------------------------------------------
    logic [WIN_BYTES-1:0][7:0] r_window;   // newest byte at index 0
    logic [WIN_BYTES-1:0][7:0] n_window;
    logic [OFFSET_BITS-1:0]    r_count;
    logic [OFFSET_BITS-1:0]    n_count;
    logic                      r_seen;
    logic [OFFSET_BITS-1:0]    r_start;
    logic [OFFSET_BITS-1:0]    n_start;
    logic                      win_hit;
    logic                      hit;
    logic                      in_acc;
    logic [63:0]               start_wide;

    assign in_acc = i_in_valid && !o_in_stall;

    // Only a buffer's last byte needs the result register, so only it waits.
    assign o_in_stall = o_out_valid && i_out_stall && i_in_data.last_byte;

    always_comb begin
        n_window[0] = i_in_data.data_byte;
        for (int k = 1; k < WIN_BYTES; k++) begin
            n_window[k] = r_window[k-1];
        end
    end

    // byte count saturates at all ones
    assign n_count = (r_count == '1) ? r_count : r_count + OFFSET_BITS'(1);
    assign n_start = n_count - OFFSET_BITS'(eff_len);

    mbpf_matcher #(
        .WIN_BYTES (WIN_BYTES)
    ) u_matcher (
        .i_window    (n_window),
        .i_signature (mbpf_pkg::t_signature'({r_pat_hi, r_pat_lo})),
        .i_care      (r_care),
        .i_len       (eff_len),
        .o_hit       (win_hit)
    );

    // a match counts only once the whole window lies inside this buffer
    assign hit = win_hit && (n_count >= OFFSET_BITS'(eff_len));

    // Window bytes left over from an earlier buffer are masked by the count
    // check, so the window itself needs no clear.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_window <= n_window;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_seen  <= 1'b0;
            r_start <= '0;
        end else if (in_acc) begin
            if (i_in_data.last_byte) begin
                r_count <= '0;
                r_seen  <= 1'b0;
                r_start <= '0;
            end else begin
                r_count <= n_count;
                if (hit) begin
                    r_seen  <= 1'b1;
                    r_start <= n_start;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    // Latest match wins: this byte's hit, else the stored one, else zero.
    assign start_wide = hit    ? 64'(n_start) :
                        r_seen ? 64'(r_start) : 64'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (in_acc && i_in_data.last_byte) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_data.last_byte) begin
            o_out_data.found        <= hit || r_seen;
            o_out_data.match_offset <= start_wide[mbpf_pkg::OUT_OFFSET_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_data.last_byte |=> o_out_valid)
        else $error("no result after last byte");

    a_last_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_data.last_byte |=> (r_count == '0) && !r_seen)
        else $error("search state not cleared at buffer end");

    a_no_find_zero_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.found |-> o_out_data.match_offset == '0)
        else $error("offset non-zero without a match");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with result register free");

endmodule : masked_byte_pattern_finder
`default_nettype wire
